FILE: sv/vnhp_pkg.sv
package vnhp_pkg;

  // byte kinds, which are also the parser phases
  localparam logic [2:0] KIND_FIRST   = 3'd0;
  localparam logic [2:0] KIND_VERSION = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_DEST    = 3'd3;
  localparam logic [2:0] KIND_SOURCE  = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  localparam logic [7:0] DEST_NIB_MASK = 8'hF0;
  localparam logic [7:0] SRC_NIB_MASK  = 8'h0F;
  localparam logic [4:0] ID_LEN_BIAS   = 5'd3;
  localparam logic [1:0] VER_LAST_OFF  = 2'd3;
  localparam logic [5:0] FIXED_HDR_LEN = 6'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
    logic [4:0]  field_offset;
    logic [31:0] version_value;
    logic [4:0]  dest_id_length;
    logic [4:0]  source_id_length;
    logic [5:0]  header_length;
    logic [1:0]  status;
  } out_item_t;

  // pipeline control between the stages
  typedef struct packed {
    logic valid;
    logic adv;
  } pipe_ctl_t;

  // zero nibble means absent id, else nibble + 3
  function automatic logic [4:0] id_len(input logic [3:0] nib);
    id_len = (nib == 4'd0) ? 5'd0 : ({1'b0, nib} + ID_LEN_BIAS);
  endfunction

endpackage

FILE: sv/vnhp_ifs.sv
interface vnhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vnhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  byte_out;
  logic [4:0]  field_offset;
  logic [31:0] version_value;
  logic [4:0]  dest_id_length;
  logic [4:0]  source_id_length;
  logic [5:0]  header_length;
  logic [1:0]  status;

  modport source (
    output valid, output byte_kind, output byte_out, output field_offset,
    output version_value, output dest_id_length, output source_id_length,
    output header_length, output status, input ready
  );
  modport sink (
    input valid, input byte_kind, input byte_out, input field_offset,
    input version_value, input dest_id_length, input source_id_length,
    input header_length, input status, output ready
  );
endinterface

FILE: sv/vnhp_in_stage.sv
module vnhp_in_stage
  import vnhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  input  in_item_t req_item,
  output logic     req_ready,
  input  logic     adv,
  output logic     stage_valid,
  output in_item_t stage_item
);

  logic     valid_r;
  in_item_t item_r;

  assign req_ready   = !valid_r || adv;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      item_r <= req_item;
    end
  end

endmodule

FILE: sv/vnhp_classifier.sv
module vnhp_classifier
  import vnhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  in_item_t  item,
  output out_item_t result
);

  logic [2:0]  phase_r, phase_nxt, phase_upd;
  logic [4:0]  offset_r, offset_nxt, offset_upd;
  logic [31:0] version_r, version_nxt, version_upd;
  logic [4:0]  dlen_r, dlen_nxt, dlen_upd;
  logic [4:0]  slen_r, slen_nxt, slen_upd;
  logic [2:0]  kind;
  logic [4:0]  off;
  logic [1:0]  stat;
  logic        partial;
  logic        last;

  assign last = item.last_byte;

  always_comb begin
    phase_upd   = phase_r;
    offset_upd  = offset_r;
    version_upd = version_r;
    dlen_upd    = dlen_r;
    slen_upd    = slen_r;
    kind        = phase_r;
    off         = offset_r;
    stat        = STAT_BUSY;
    partial     = 1'b0;
    unique case (phase_r)
      KIND_FIRST: begin
        phase_upd  = KIND_VERSION;
        offset_upd = 5'd0;
        partial    = 1'b1;
      end
      KIND_VERSION: begin
        version_upd = {version_r[23:0], item.data_byte};
        if (offset_r >= {3'd0, VER_LAST_OFF}) begin
          phase_upd  = KIND_LENGTH;
          offset_upd = 5'd0;
        end else begin
          offset_upd = offset_r + 5'd1;
        end
        partial = 1'b1;
      end
      KIND_LENGTH: begin
        off        = 5'd0;
        dlen_upd   = id_len(4'((item.data_byte & DEST_NIB_MASK) >> 4));
        slen_upd   = id_len(4'(item.data_byte & SRC_NIB_MASK));
        offset_upd = 5'd0;
        if (last) begin
          partial = 1'b1;
        end else if (dlen_upd != 5'd0) begin
          phase_upd = KIND_DEST;
        end else if (slen_upd != 5'd0) begin
          phase_upd = KIND_SOURCE;
        end else begin
          phase_upd = KIND_PAYLOAD;
          stat      = STAT_DONE;
        end
      end
      KIND_DEST: begin
        if (({1'b0, offset_r} + 6'd1) >= {1'b0, dlen_r}) begin
          offset_upd = 5'd0;
          if (slen_r != 5'd0) begin
            phase_upd = KIND_SOURCE;
            partial   = 1'b1;
          end else begin
            phase_upd = KIND_PAYLOAD;
            stat      = STAT_DONE;
          end
        end else begin
          offset_upd = offset_r + 5'd1;
          partial    = 1'b1;
        end
      end
      KIND_SOURCE: begin
        if (({1'b0, offset_r} + 6'd1) >= {1'b0, slen_r}) begin
          offset_upd = 5'd0;
          phase_upd  = KIND_PAYLOAD;
          stat       = STAT_DONE;
        end else begin
          offset_upd = offset_r + 5'd1;
          partial    = 1'b1;
        end
      end
      default: begin
        // payload, and the unreachable codes fold into it
        kind       = KIND_PAYLOAD;
        off        = 5'd0;
        phase_upd  = KIND_PAYLOAD;
        offset_upd = 5'd0;
      end
    endcase
    if (last && partial) begin
      stat = STAT_TRUNC;
    end

    // packet boundary puts everything back to reset values
    if (last) begin
      phase_nxt   = KIND_FIRST;
      offset_nxt  = 5'd0;
      version_nxt = 32'd0;
      dlen_nxt    = 5'd0;
      slen_nxt    = 5'd0;
    end else begin
      phase_nxt   = phase_upd;
      offset_nxt  = offset_upd;
      version_nxt = version_upd;
      dlen_nxt    = dlen_upd;
      slen_nxt    = slen_upd;
    end

    result.byte_kind        = kind;
    result.byte_out         = item.data_byte;
    result.field_offset     = off;
    result.version_value    = version_upd;
    result.dest_id_length   = dlen_upd;
    result.source_id_length = slen_upd;
    result.header_length    = (stat == STAT_DONE)
                              ? (FIXED_HDR_LEN + {1'b0, dlen_upd} + {1'b0, slen_upd})
                              : 6'd0;
    result.status           = stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= KIND_FIRST;
      offset_r  <= 5'd0;
      version_r <= 32'd0;
      dlen_r    <= 5'd0;
      slen_r    <= 5'd0;
    end else if (ctl.valid && ctl.adv) begin
      phase_r   <= phase_nxt;
      offset_r  <= offset_nxt;
      version_r <= version_nxt;
      dlen_r    <= dlen_nxt;
      slen_r    <= slen_nxt;
    end
  end

endmodule

FILE: sv/vnhp_out_stage.sv
module vnhp_out_stage
  import vnhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      stage_valid,
  input  out_item_t result,
  input  logic      res_ready,
  output logic      res_valid,
  output out_item_t res_item,
  output pipe_ctl_t ctl
);

  logic      valid_r;
  out_item_t item_r;

  assign ctl.valid = stage_valid;
  assign ctl.adv   = stage_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      item_r <= result;
    end
  end

endmodule

FILE: sv/version_negotiation_header_parser.sv
// Version negotiation header parser. Takes one packet byte per request on
// in_chan, with last_byte set on the final byte, and returns one result per
// byte on out_chan: the byte's kind (first, version, length byte, destination
// id, source id, payload), its offset in the field, the version assembled so
// far, the decoded id lengths (nibble 0 is absent, otherwise nibble + 3), the
// header length on the byte that completes the header, and a status of in
// progress, header complete or truncated. Sustained rate is one byte per
// clock while out_chan.ready stays high. Each byte passes through the input
// register and then the result register, with the combinational classifier
// between them, whose phase and offset registers update as each byte moves
// into the result register. After any last byte the parser is back in its
// reset state for the next packet.
module version_negotiation_header_parser
  import vnhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  vnhp_in_if.sink     in_chan,
  vnhp_out_if.source  out_chan
);

  in_item_t  in_item;
  in_item_t  stage_item;
  logic      stage_valid;
  out_item_t result;
  out_item_t res_item;
  pipe_ctl_t ctl;

  assign in_item.data_byte = in_chan.data_byte;
  assign in_item.last_byte = in_chan.last_byte;

  // input register, takes a request when empty or when the byte it holds moves on
  vnhp_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_chan.valid),
    .req_item    (in_item),
    .req_ready   (in_chan.ready),
    .adv         (ctl.adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // classify the held byte and advance the header state
  vnhp_classifier u_classifier (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (stage_item),
    .result (result)
  );

  // result register, frees itself when the sink takes the result
  vnhp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .result      (result),
    .res_ready   (out_chan.ready),
    .res_valid   (out_chan.valid),
    .res_item    (res_item),
    .ctl         (ctl)
  );

  assign out_chan.byte_kind        = res_item.byte_kind;
  assign out_chan.byte_out         = res_item.byte_out;
  assign out_chan.field_offset     = res_item.field_offset;
  assign out_chan.version_value    = res_item.version_value;
  assign out_chan.dest_id_length   = res_item.dest_id_length;
  assign out_chan.source_id_length = res_item.source_id_length;
  assign out_chan.header_length    = res_item.header_length;
  assign out_chan.status           = res_item.status;

endmodule
